FILE: src/dsi64_pkg.sv
// ============================================================================
// dsi64_pkg - shared types and constants for the decimal string parser
// Character codes and the parser phase encoding.
// ============================================================================
`default_nettype none

package dsi64_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30; // '0'
    localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31; // '1'
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39; // '9'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D; // '-'

    // Radix 10 as shift-and-add: m * 10 = (m << 3) + (m << 1).
    localparam int RADIX_SHIFT_HI = 3;
    localparam int RADIX_SHIFT_LO = 1;
    localparam int ACC_W          = VALUE_W + 4;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_MINUS  = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

endpackage : dsi64_pkg

`default_nettype wire

FILE: src/decimal_string_to_int64_top.sv
// ============================================================================
// decimal_string_to_int64_top - strict decimal ASCII to signed 64-bit parser
// Streams one character per word and returns a success flag and value.
// ============================================================================
`default_nettype none

// Accepts one character word per cycle and returns one result word on the
// word that carries tlast. Syntax: optional leading '-', first digit 1..9,
// then digits 0..9; the lone string "0" is the only zero. A word with
// tuser = 0 carries no character: with tlast it ends the string (an empty
// string fails), without tlast it is dropped. Any syntax error, unsigned
// 64-bit overflow or out-of-range magnitude gives ok = 0 and value = 0.
// Each word passes through an input register, the accumulate and range
// logic (a shift-and-add multiply by ten and a 68-bit overflow check) and
// a result register; the sustained rate is one word per cycle except where
// a terminating word stalls. The result register parts the two sides:
// characters keep flowing while a finished result waits, and only a
// terminating word stalls behind an untaken result.
module decimal_string_to_int64_top
    import dsi64_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [CHAR_W-1:0]  s_tdata,   // [7:0] char_code
    input  wire logic               s_tuser,   // [0] has_char
    input  wire logic               s_tlast,   // last_char

    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [VALUE_W-1:0]      m_tdata,   // [63:0] value (signed)
    output logic                    m_tuser    // [0] ok
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_has_reg;
    logic              in_last_reg;

    // Parser state
    phase_t            phase_reg,  phase_next;
    logic              neg_reg,    neg_next;
    logic [VALUE_W-1:0] mag_reg,   mag_next;
    logic              failed_reg, failed_next;

    // Result register
    logic               out_valid_reg;
    logic               out_ok_reg,    out_ok_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;

    logic out_free;
    logic advance;
    logic emit;

    // Output slot is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_tready;
    // Only the terminating word needs the output slot.
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign emit     = advance && in_last_reg;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Character decode and accumulate
    // ------------------------------------------------------------------
    logic               is_digit;
    logic               is_nonzero_digit;
    logic [VALUE_W-1:0] digit_val;
    logic [ACC_W-1:0]   acc_sum;
    logic               acc_ovf;
    logic               lone_zero;
    logic               in_range;

    assign is_digit         = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);
    assign is_nonzero_digit = (in_char_reg >= CHAR_ONE)  && (in_char_reg <= CHAR_NINE);
    assign digit_val        = {{(VALUE_W-4){1'b0}}, in_char_reg[3:0]};

    // m * 10 + d in a widened sum; any carry above bit 63 is overflow.
    assign acc_sum = ({4'b0000, mag_reg} << RADIX_SHIFT_HI)
                   + ({4'b0000, mag_reg} << RADIX_SHIFT_LO)
                   + {4'b0000, digit_val};
    assign acc_ovf = |acc_sum[ACC_W-1:VALUE_W];

    always_comb begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        failed_next = failed_reg;
        lone_zero   = 1'b0;

        if (in_has_reg && !failed_reg) begin
            unique case (phase_reg)
                PH_FIRST: begin
                    if (in_char_reg == CHAR_ZERO) begin
                        if (in_last_reg) begin
                            lone_zero = 1'b1;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end else if (in_char_reg == CHAR_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_MINUS;
                    end else if (is_nonzero_digit) begin
                        mag_next   = digit_val;
                        phase_next = PH_DIGITS;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_MINUS: begin
                    if (is_nonzero_digit) begin
                        mag_next   = digit_val;
                        phase_next = PH_DIGITS;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit && !acc_ovf) begin
                        mag_next = acc_sum[VALUE_W-1:0];
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                default: begin
                    failed_next = 1'b1;
                end
            endcase
        end

        // Range: up to 2^63 when negative, up to 2^63-1 otherwise.
        if (neg_next) begin
            in_range = !mag_next[VALUE_W-1] || (mag_next[VALUE_W-2:0] == '0);
        end else begin
            in_range = !mag_next[VALUE_W-1];
        end

        out_ok_next    = lone_zero
                       || (!failed_next && (phase_next == PH_DIGITS) && in_range);
        out_value_next = '0;
        if (out_ok_next && !lone_zero) begin
            out_value_next = neg_next ? (~mag_next + VALUE_W'(1)) : mag_next;
        end

        // Restart the parser after the terminating word.
        if (in_last_reg) begin
            phase_next  = PH_FIRST;
            neg_next    = 1'b0;
            mag_next    = '0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FIRST;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            failed_reg <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            mag_reg    <= mag_next;
            failed_reg <= failed_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on emit, hold while stalled, drop when taken
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_ok_reg    <= out_ok_next;
            out_value_reg <= out_value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = out_value_reg;

`ifndef SYNTHESIS
    // A failed parse must report a zero value.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed result carries nonzero value");

    // The parser is back at its start after every terminating word.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (phase_reg == PH_FIRST) && !neg_reg && !failed_reg && (mag_reg == '0))
        else $error("parser state not cleared after result");

    // An empty input register always takes a new word.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

    // Hold a stalled result word unchanged until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");
`endif

endmodule : decimal_string_to_int64_top

`default_nettype wire
